>>> design/bdda_pkg.sv
package bdda_pkg;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 15;

	// width of the weekday sum and of the shared multiplier operands
	localparam int SUM_W   = 15;
	localparam int KMUL_W  = 15;
	localparam int PROD_W  = SUM_W + KMUL_W;

	// reciprocal constants: x / 100 = (x * RECIP100) >> 19, x / 7 = (x * RECIP7) >> 17
	localparam logic [KMUL_W-1:0] RECIP100 = KMUL_W'(5243);
	localparam int                SHIFT100 = 19;
	localparam logic [KMUL_W-1:0] RECIP7   = KMUL_W'(18725);
	localparam int                SHIFT7   = 17;

	localparam int Q100_W = PROD_W - SHIFT100;
	localparam int Q7_W   = PROD_W - SHIFT7;

	// month codes
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	// weekday orders, sunday is zero
	localparam logic [2:0] WD_FRI = 3'd5;
	localparam logic [2:0] WD_SAT = 3'd6;

	// position of the current year inside its century
	localparam logic [6:0] YEAR_LAST_IN_CENTURY = 7'd99;
	localparam logic [6:0] CENTURY             = 7'd100;

	// length of a month, zero for a month code that means nothing
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// month term of the weekday sum: (31 * shifted month) / 12, march is month one
	function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] t;
		case (m)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

>>> design/business_day_date_adder.sv
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | start_day, start_month, start_year, business_days
// output   | out_valid | out_stall | end_day, end_month, end_year, date_error
//
// one transaction at a time: in_stall is high from acceptance until the result is taken
// setup uses one shared multiplier for the /100 and mod 7 steps, then the
// calendar walk advances one calendar day at a time until the count is spent
// an invalid start date skips the mod 7 steps and the walk, and its result follows S_SUM
// reset clears the sequencer only; the result is held while out_stall is high
module business_day_date_adder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bdda_pkg::DAY_W-1:0]   start_day,
	input  logic [bdda_pkg::MONTH_W-1:0] start_month,
	input  logic [bdda_pkg::YEAR_W-1:0]  start_year,
	input  logic [bdda_pkg::COUNT_W-1:0] business_days,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bdda_pkg::DAY_W-1:0]   end_day,
	output logic [bdda_pkg::MONTH_W-1:0] end_month,
	output logic [bdda_pkg::YEAR_W-1:0]  end_year,
	output logic                         date_error
);
	import bdda_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_Y100 = 7'b0000010,
		S_YREM = 7'b0000100,
		S_SUM  = 7'b0001000,
		S_MOD7 = 7'b0010000,
		S_REM7 = 7'b0100000,
		S_WALK = 7'b1000000
	} state_t;

	// S_WALK doubles as the result state once the count is spent or the start date is invalid
	state_t              state_q;
	logic                done_q;

	logic [DAY_W-1:0]    d_q;
	logic [MONTH_W-1:0]  m_q;
	logic [YEAR_W-1:0]   y_q;
	logic [COUNT_W-1:0]  n_q;
	logic [2:0]          wd_q;
	logic [6:0]          ymod100_q;
	logic [1:0]          cent_q;
	logic                err_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_q;

	logic [SUM_W-1:0]    mul_a;
	logic [KMUL_W-1:0]   mul_k;
	logic [YEAR_W-1:0]   yy;
	logic [Q100_W-1:0]   q100;
	logic [Q7_W-1:0]     q7;
	logic                leap;
	logic [DAY_W-1:0]    dim;
	logic                bad_date;
	logic [SUM_W-1:0]    wd_sum;

	// leap year from the position inside the century and the century count mod 4
	assign leap = (ymod100_q == 7'd0) ? (cent_q == 2'd0) : (ymod100_q[1:0] == 2'd0);
	assign dim  = month_days(m_q, leap);

	// january and february count as months of the previous year
	assign yy = (m_q <= MONTH_FEB) ? (y_q - YEAR_W'(1)) : y_q;

	assign q100 = prod_q[PROD_W-1:SHIFT100];
	assign q7   = prod_q[PROD_W-1:SHIFT7];

	// shared multiplier operand selection
	always_comb begin
		case (state_q)
			S_Y100: begin
				mul_a = SUM_W'(y_q);
				mul_k = RECIP100;
			end
			S_YREM: begin
				mul_a = SUM_W'(yy);
				mul_k = RECIP100;
			end
			default: begin
				mul_a = sum_q;
				mul_k = RECIP7;
			end
		endcase
	end

	// start date check and weekday sum, the product holds yy * RECIP100 here
	assign bad_date = (y_q == YEAR_W'(0)) || (m_q < MONTH_JAN) || (m_q > MONTH_DEC)
		|| (d_q == DAY_W'(0)) || (d_q > dim);
	assign wd_sum = SUM_W'(d_q) + SUM_W'(yy) + SUM_W'(yy >> 2) - SUM_W'(q100)
		+ SUM_W'(q100 >> 2) + SUM_W'(month_term(m_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_Y100;
					end
				end
				S_Y100: state_q <= S_YREM;
				S_YREM: state_q <= S_SUM;
				S_SUM: begin
					if (bad_date) begin
						state_q <= S_WALK;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_MOD7;
					end
				end
				S_MOD7: state_q <= S_REM7;
				S_REM7: state_q <= S_WALK;
				S_WALK: begin
					if (done_q) begin
						if (!out_stall) begin
							state_q <= S_IDLE;
							done_q  <= 1'b0;
						end
					end else if (n_q == COUNT_W'(0)) begin
						done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_k);
		case (state_q)
			S_IDLE: begin
				d_q <= start_day;
				m_q <= start_month;
				y_q <= start_year;
				n_q <= business_days;
			end
			S_YREM: begin
				ymod100_q <= 7'(y_q - YEAR_W'(q100) * YEAR_W'(CENTURY));
				cent_q    <= q100[1:0];
			end
			S_SUM: begin
				err_q <= bad_date;
				sum_q <= wd_sum;
			end
			S_REM7: begin
				wd_q <= 3'(sum_q - SUM_W'(q7) * SUM_W'(7));
			end
			S_WALK: begin
				// one calendar day per cycle, count only days other than friday and saturday
				if (!done_q && n_q != COUNT_W'(0)) begin
					if (wd_q != WD_FRI && wd_q != WD_SAT) begin
						n_q <= n_q - COUNT_W'(1);
					end
					wd_q <= (wd_q == WD_SAT) ? 3'd0 : wd_q + 3'd1;
					if (d_q == dim) begin
						d_q <= DAY_W'(1);
						if (m_q == MONTH_DEC) begin
							m_q <= MONTH_JAN;
							y_q <= y_q + YEAR_W'(1);
							if (ymod100_q == YEAR_LAST_IN_CENTURY) begin
								ymod100_q <= 7'd0;
								cent_q    <= cent_q + 2'd1;
							end else begin
								ymod100_q <= ymod100_q + 7'd1;
							end
						end else begin
							m_q <= m_q + MONTH_W'(1);
						end
					end else begin
						d_q <= d_q + DAY_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_WALK) && done_q;
	assign end_day    = d_q;
	assign end_month  = m_q;
	assign end_year   = y_q;
	assign date_error = err_q;

endmodule

>>> design/bdda_checker.sv
module bdda_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [bdda_pkg::DAY_W-1:0]   end_day,
	input logic [bdda_pkg::MONTH_W-1:0] end_month,
	input logic [bdda_pkg::YEAR_W-1:0]  end_year,
	input logic                         date_error
);
	import bdda_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(end_day) && $stable(end_month)
			&& $stable(end_year) && $stable(date_error))
		else $error("stalled result changed");

	// no result is shown while the block is taking input
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result shown while idle");

	// accepting a transaction raises in_stall and shows no result yet
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("input not blocked after acceptance");

	// a walked date has a month in range and a nonzero day
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !date_error |-> end_month >= MONTH_JAN && end_month <= MONTH_DEC
			&& end_day != DAY_W'(0))
		else $error("walked date out of range");

endmodule

bind business_day_date_adder bdda_checker u_bdda_checker (.*);
